FILE: src/cbcv_pkg.sv
// Shared types, constants and letter arithmetic for the CBC Vigenere encryptor.
package cbcv_pkg;

    // Alphabet and character constants.
    localparam logic [5:0] ALPHA_SIZE   = 6'd26;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [6:0] ASCII_BASE   = 7'h61;
    localparam logic [4:0] PAD_LETTER   = 5'd23;

    // Configuration port layout.
    localparam int         CFG_DATA_W    = 60;
    localparam int         CFG_IDX_W     = 2;
    localparam int         SLOT_W        = 5;
    localparam logic [1:0] REG_BLOCK_LEN = 2'd0;
    localparam logic [1:0] REG_KEY       = 2'd1;
    localparam logic [1:0] REG_IV        = 2'd2;

    // Input function codes.
    localparam logic FUNC_TEXT = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Result kinds.
    localparam logic KIND_LETTER  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One input request.
    typedef struct packed {
        logic       func;
        logic [7:0] text_byte;
    } in_t;

    // One result item.
    typedef struct packed {
        logic        kind;
        logic [6:0]  cipher_letter;
        logic        is_pad;
        logic [15:0] clean_count;
        logic [3:0]  pad_count;
        logic        last_of_run;
    } out_t;

    // Commands from the sequencer to the chain core.
    typedef struct packed {
        logic       encrypt;
        logic [4:0] plain;
        logic       count_letter;
        logic       load_chain;
        logic       clear_run;
    } core_cmd_t;

    // Fold a five-bit slot value into the range 0 to 25.
    function automatic logic [4:0] fold_mod26(input logic [4:0] v);
        logic [5:0] w;
        begin
            w = {1'b0, v};
            fold_mod26 = (w >= ALPHA_SIZE) ? 5'(w - ALPHA_SIZE) : v;
        end
    endfunction

    // Sum of two letters, both 0 to 25, taken mod 26.
    function automatic logic [4:0] add_mod26(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            add_mod26 = (s >= ALPHA_SIZE) ? 5'(s - ALPHA_SIZE) : 5'(s);
        end
    endfunction

    // Effective block length: zero acts as one, values above the maximum clamp.
    function automatic logic [3:0] eff_block_len(input logic [3:0] n, input logic [3:0] max_len);
        begin
            if (n == 4'd0)
                eff_block_len = 4'd1;
            else if (n > max_len)
                eff_block_len = max_len;
            else
                eff_block_len = n;
        end
    endfunction

endpackage

FILE: src/cbcv_chain_core.sv
// Chain block, block position and letter count with the per-letter cipher add.
module cbcv_chain_core #(
    parameter int MAX_BLOCK  = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cbcv_pkg::core_cmd_t                    cmd,
    input  logic [3:0]                             eff_len,
    input  logic [cbcv_pkg::CFG_DATA_W-1:0]        key_letters,
    input  logic [cbcv_pkg::CFG_DATA_W-1:0]        iv_letters,
    output logic [4:0]                             cipher,
    output logic [((MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1)-1:0] pos,
    output logic [COUNT_BITS-1:0]                  count
);

    localparam int POS_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    logic [4:0]            chain_reg [MAX_BLOCK];
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [4:0]            key_slot;
    logic [4:0]            pos_inc;

    // Cipher letter for the current position.
    always_comb
    begin
        key_slot = cbcv_pkg::fold_mod26(key_letters[pos_reg * cbcv_pkg::SLOT_W +: cbcv_pkg::SLOT_W]);
        cipher   = cbcv_pkg::add_mod26(cbcv_pkg::add_mod26(cmd.plain, key_slot),
                                       chain_reg[pos_reg]);
    end

    // Advance the position, closing the block at the effective length.
    always_comb
    begin
        pos_inc = 5'(pos_reg) + 5'd1;
        if (pos_inc >= {1'b0, eff_len})
            pos_next = '0;
        else
            pos_next = POS_W'(pos_inc);
    end

    // Chain block: reload from the IV, or store the new cipher letter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BLOCK; i++)
            begin
                chain_reg[i] <= '0;
            end
        end
        else if (cmd.load_chain)
        begin
            for (int i = 0; i < MAX_BLOCK; i++)
            begin
                chain_reg[i] <= cbcv_pkg::fold_mod26(
                    iv_letters[i * cbcv_pkg::SLOT_W +: cbcv_pkg::SLOT_W]);
            end
        end
        else if (cmd.encrypt)
        begin
            chain_reg[pos_reg] <= cipher;
        end
    end

    // Position and saturating letter count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.clear_run)
                pos_reg <= '0;
            else if (cmd.encrypt)
                pos_reg <= pos_next;

            if (cmd.clear_run)
                count_reg <= '0;
            else if (cmd.count_letter && (count_reg != {COUNT_BITS{1'b1}}))
                count_reg <= count_reg + COUNT_BITS'(1);
        end
    end

    assign pos   = pos_reg;
    assign count = count_reg;

endmodule

FILE: src/cbc_vigenere_encryptor_top.sv
// Top level: request handshake, end-of-message pad sequencer and output skid stage.
// A letter's result is registered in out_data_reg, or in the skid stage if that is held.
// Throughput: one text byte per cycle while in_stall is low; the chain core updates
// one position per cycle. End of message: the pads then the summary leave one per cycle
// while the skid stage is empty; input is stalled until the summary has been produced.
// Reset: asynchronous; block_len returns to 1, key, IV, chain, position and count to 0.
module cbc_vigenere_encryptor_top #(
    parameter int MAX_BLOCK  = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  cbcv_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output cbcv_pkg::out_t                      out_data,
    input  logic                                cfg_we,
    input  logic [cbcv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbcv_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int POS_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    // Configuration registers.
    logic [3:0]                        block_len_reg;
    logic [cbcv_pkg::CFG_DATA_W-1:0]   key_reg;
    logic [cbcv_pkg::CFG_DATA_W-1:0]   iv_reg;
    logic [cbcv_pkg::CFG_DATA_W-1:0]   iv_next;
    logic                              iv_write;

    // Sequencer and output stage.
    logic                   flush_active_reg;
    logic [3:0]             pads_left_reg;
    logic [3:0]             pads_total_reg;
    logic                   out_valid_reg;
    cbcv_pkg::out_t         out_data_reg;
    logic                   skid_valid_reg;
    cbcv_pkg::out_t         skid_data_reg;

    logic                   in_fire;
    logic                   is_upper;
    logic                   is_lower;
    logic [4:0]             letter_val;
    logic                   letter_fire;
    logic                   end_fire;
    logic                   flush_step;
    logic                   pad_step;
    logic                   summary_step;
    logic [3:0]             eff_len;
    logic [3:0]             pads_at_end;
    logic [32:0]            count_ext;
    logic [15:0]            clean_sat;
    logic                   push;
    cbcv_pkg::out_t         push_data;
    logic                   pop;
    cbcv_pkg::core_cmd_t    cmd;
    logic [4:0]             cipher;
    logic [POS_W-1:0]       pos;
    logic [COUNT_BITS-1:0]  count;

    // Configuration writes; an IV write also reloads the chain.
    assign iv_write = cfg_we && (cfg_index == cbcv_pkg::REG_IV);
    assign iv_next  = iv_write ? cfg_data : iv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len_reg <= 4'd1;
            key_reg       <= '0;
            iv_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cbcv_pkg::REG_BLOCK_LEN: block_len_reg <= cfg_data[3:0];
                cbcv_pkg::REG_KEY:       key_reg       <= cfg_data;
                cbcv_pkg::REG_IV:        iv_reg        <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign eff_len = cbcv_pkg::eff_block_len(block_len_reg, 4'(MAX_BLOCK));

    // Request decode: fold case, drop non-letters.
    always_comb
    begin
        is_upper = (in_data.text_byte >= cbcv_pkg::CHAR_UPPER_A) &&
                   (in_data.text_byte <= cbcv_pkg::CHAR_UPPER_Z);
        is_lower = (in_data.text_byte >= cbcv_pkg::CHAR_LOWER_A) &&
                   (in_data.text_byte <= cbcv_pkg::CHAR_LOWER_Z);
        if (is_upper)
            letter_val = 5'(in_data.text_byte - cbcv_pkg::CHAR_UPPER_A);
        else
            letter_val = 5'(in_data.text_byte - cbcv_pkg::CHAR_LOWER_A);
    end

    assign in_stall     = skid_valid_reg || flush_active_reg;
    assign in_fire      = in_valid && !in_stall;
    assign letter_fire  = in_fire && (in_data.func == cbcv_pkg::FUNC_TEXT) &&
                          (is_upper || is_lower);
    assign end_fire     = in_fire && (in_data.func == cbcv_pkg::FUNC_END);
    assign flush_step   = flush_active_reg && !skid_valid_reg;
    assign pad_step     = flush_step && (pads_left_reg != 4'd0);
    assign summary_step = flush_step && (pads_left_reg == 4'd0);

    // Pads needed to close a partial block.
    assign pads_at_end = ((pos != '0) && (4'(pos) < eff_len)) ? (eff_len - 4'(pos)) : 4'd0;

    // Clean count as seen on the 16-bit summary field.
    always_comb
    begin
        count_ext = 33'(count);
        clean_sat = (count_ext > 33'd65535) ? 16'hFFFF : count_ext[15:0];
    end

    // Commands to the chain core.
    always_comb
    begin
        cmd.encrypt      = letter_fire || pad_step;
        cmd.plain        = pad_step ? cbcv_pkg::PAD_LETTER : letter_val;
        cmd.count_letter = letter_fire;
        cmd.load_chain   = iv_write || summary_step;
        cmd.clear_run    = summary_step;
    end

    cbcv_chain_core #(
        .MAX_BLOCK  (MAX_BLOCK),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .eff_len     (eff_len),
        .key_letters (key_reg),
        .iv_letters  (iv_next),
        .cipher      (cipher),
        .pos         (pos),
        .count       (count)
    );

    // Result produced this cycle.
    always_comb
    begin
        push                    = letter_fire || flush_step;
        push_data.kind          = summary_step ? cbcv_pkg::KIND_SUMMARY : cbcv_pkg::KIND_LETTER;
        push_data.cipher_letter = summary_step ? 7'd0 : (cbcv_pkg::ASCII_BASE + 7'(cipher));
        push_data.is_pad        = pad_step;
        push_data.clean_count   = summary_step ? clean_sat : 16'd0;
        push_data.pad_count     = summary_step ? pads_total_reg : 4'd0;
        push_data.last_of_run   = letter_fire || summary_step;
    end

    // End-of-message sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_active_reg <= 1'b0;
            pads_left_reg    <= 4'd0;
            pads_total_reg   <= 4'd0;
        end
        else if (end_fire)
        begin
            flush_active_reg <= 1'b1;
            pads_left_reg    <= pads_at_end;
            pads_total_reg   <= pads_at_end;
        end
        else if (pad_step)
        begin
            pads_left_reg <= pads_left_reg - 4'd1;
        end
        else if (summary_step)
        begin
            flush_active_reg <= 1'b0;
        end
    end

    // Output register with a skid stage behind it.
    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // The skid stage only fills behind a held output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
    else $error("skid stage valid while output register empty");

    // An accepted end of message starts the pad sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        end_fire |=> flush_active_reg)
    else $error("end of message did not start the flush");

    // Pads still to send never exceed the pads counted at end of message.
    assert property (@(posedge clk) disable iff (!rst_n)
        flush_active_reg |-> (pads_left_reg <= pads_total_reg))
    else $error("pad counter ran past its total");

    // A summary carries no letter and closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.kind == cbcv_pkg::KIND_SUMMARY)) |->
        (!out_data_reg.is_pad && out_data_reg.last_of_run && (out_data_reg.cipher_letter == 7'd0)))
    else $error("malformed summary result");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the CBC Vigenere encryptor top level.
`timescale 1ns / 100ps

module tb;

    localparam int         MAX_BLOCK    = 12;
    localparam int         COUNT_BITS   = 16;
    localparam logic [1:0] REG_NONE     = 2'd3;
    localparam int         N_DIR        = 39;
    localparam int         RAND_ITEMS   = 230;
    localparam int         TAIL_LETTERS = 30;
    localparam int         HOLD_CYCLES  = 120;
    localparam int         SETTLE       = 4;
    localparam int         DRAIN_LIMIT  = 5000;
    localparam int         LIMIT_CYCLES = 600000;

    typedef enum logic [1:0] {ROW_REQ, ROW_CFG} row_op_t;

    // One line of the directed table: a request or a register write.
    typedef struct {
        row_op_t         op;
        cbcv_pkg::in_t   req;
        logic [1:0]      reg_idx;
        logic [59:0]     reg_val;
        bit              typed;
        cbcv_pkg::out_t  res;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    cbcv_pkg::in_t                   in_data = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    cbcv_pkg::out_t                  out_data;
    logic                            cfg_we = 1'b0;
    logic [cbcv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cbcv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the registers and the cipher state.
    logic [3:0]  cfg_blen;
    logic [59:0] cfg_key;
    logic [59:0] cfg_iv;
    logic [4:0]  chain_pred [MAX_BLOCK];
    logic [3:0]  pos_pred;
    logic [15:0] count_pred;

    cbcv_pkg::out_t pending_results [$];
    int             fail_count = 0;
    int             req_total = 0;
    int             cycle_count = 0;
    bit             idle_on = 1'b0;
    bit             long_hold = 1'b0;
    stim_row_t      dir_tab [N_DIR];

    cbc_vigenere_encryptor_top #(
        .MAX_BLOCK  (MAX_BLOCK),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("cbc_vigenere_encryptor_top verification failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        fail_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Key or IV letter at one slot, folded into the alphabet.
    function automatic logic [4:0] slot_letter(input logic [59:0] word, input int idx);
        logic [4:0] v;
        v = word[5*idx +: 5];
        return 5'(int'(v) % int'(cbcv_pkg::ALPHA_SIZE));
    endfunction

    function automatic int block_size();
        if (cfg_blen == 4'd0)
            return 1;
        if (int'(cfg_blen) > MAX_BLOCK)
            return MAX_BLOCK;
        return int'(cfg_blen);
    endfunction

    function automatic void reload_chain();
        for (int i = 0; i < MAX_BLOCK; i++)
            chain_pred[i] = slot_letter(cfg_iv, i);
    endfunction

    // Encrypt one letter at the current block position and step the position.
    function automatic logic [6:0] encipher(input logic [4:0] p);
        int ps;
        int c;
        ps = int'(pos_pred) % MAX_BLOCK;
        c = (int'(p) + int'(slot_letter(cfg_key, ps)) + int'(chain_pred[ps]))
            % int'(cbcv_pkg::ALPHA_SIZE);
        chain_pred[ps] = 5'(c);
        pos_pred = (ps + 1 >= block_size()) ? 4'd0 : 4'(ps + 1);
        return cbcv_pkg::ASCII_BASE + 7'(c);
    endfunction

    // Work out the results of one request and queue them.
    function automatic void predict_encryption(input cbcv_pkg::in_t r);
        logic [7:0]     b;
        cbcv_pkg::out_t o;
        int             pads;
        if (r.func == cbcv_pkg::FUNC_TEXT)
        begin
            b = r.text_byte;
            if (b >= cbcv_pkg::CHAR_UPPER_A && b <= cbcv_pkg::CHAR_UPPER_Z)
                b = b - cbcv_pkg::CHAR_UPPER_A + cbcv_pkg::CHAR_LOWER_A;
            if (b >= cbcv_pkg::CHAR_LOWER_A && b <= cbcv_pkg::CHAR_LOWER_Z)
            begin
                o = '0;
                o.kind = cbcv_pkg::KIND_LETTER;
                o.cipher_letter = encipher(5'(b - cbcv_pkg::CHAR_LOWER_A));
                o.last_of_run = 1'b1;
                if (count_pred != '1)
                    count_pred++;
                pending_results.push_back(o);
            end
        end
        else
        begin
            // Pad only a block that is still open and inside the current length.
            pads = (pos_pred != 4'd0 && int'(pos_pred) < block_size())
                   ? block_size() - int'(pos_pred) : 0;
            for (int i = 0; i < pads; i++)
            begin
                o = '0;
                o.kind = cbcv_pkg::KIND_LETTER;
                o.cipher_letter = encipher(cbcv_pkg::PAD_LETTER);
                o.is_pad = 1'b1;
                pending_results.push_back(o);
            end
            o = '0;
            o.kind = cbcv_pkg::KIND_SUMMARY;
            o.clean_count = count_pred;
            o.pad_count = 4'(pads);
            o.last_of_run = 1'b1;
            pending_results.push_back(o);
            reload_chain();
            pos_pred = 4'd0;
            count_pred = '0;
        end
    endfunction

    function automatic cbcv_pkg::in_t text_req(input logic [7:0] b);
        cbcv_pkg::in_t r;
        r.func = cbcv_pkg::FUNC_TEXT;
        r.text_byte = b;
        return r;
    endfunction

    function automatic cbcv_pkg::in_t end_req(input logic [7:0] b);
        cbcv_pkg::in_t r;
        r.func = cbcv_pkg::FUNC_END;
        r.text_byte = b;
        return r;
    endfunction

    function automatic stim_row_t row_text(input logic [7:0] b);
        stim_row_t row;
        row.op = ROW_REQ;
        row.req = text_req(b);
        row.reg_idx = cbcv_pkg::REG_BLOCK_LEN;
        row.reg_val = '0;
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic stim_row_t row_text_is(input logic [7:0] b, input logic [6:0] ch);
        stim_row_t row;
        row = row_text(b);
        row.typed = 1'b1;
        row.res.kind = cbcv_pkg::KIND_LETTER;
        row.res.cipher_letter = ch;
        row.res.last_of_run = 1'b1;
        return row;
    endfunction

    function automatic stim_row_t row_end(input logic [7:0] b);
        stim_row_t row;
        row = row_text(b);
        row.req = end_req(b);
        return row;
    endfunction

    function automatic stim_row_t row_end_is(input logic [7:0] b, input logic [15:0] clean,
                                             input logic [3:0] pads);
        stim_row_t row;
        row = row_end(b);
        row.typed = 1'b1;
        row.res.kind = cbcv_pkg::KIND_SUMMARY;
        row.res.clean_count = clean;
        row.res.pad_count = pads;
        row.res.last_of_run = 1'b1;
        return row;
    endfunction

    function automatic stim_row_t row_reg(input logic [1:0] idx, input logic [59:0] val);
        stim_row_t row;
        row = row_text(8'h00);
        row.op = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic logic [59:0] rand_letters();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[59:0];
    endfunction

    // Mostly letters of either case, with some raw noise bytes when allowed.
    function automatic logic [7:0] rand_text(input bit with_noise);
        int pick;
        pick = $urandom_range(0, 9);
        if (with_noise && pick == 0)
            return 8'($urandom_range(0, 255));
        if (pick < 4)
            return cbcv_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
        return cbcv_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
    endfunction

    // Stop offering requests and let every pending result drain out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write on an idle block, mirrored in the shadow copy.
    task automatic write_reg(input logic [1:0] idx, input logic [59:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            cbcv_pkg::REG_BLOCK_LEN: cfg_blen = val[3:0];
            cbcv_pkg::REG_KEY:       cfg_key = val;
            cbcv_pkg::REG_IV:
            begin
                cfg_iv = val;
                reload_chain();
            end
            default: ;
        endcase
    endtask

    // Offer one request, optionally after an idle burst, and wait until it is taken.
    task automatic send_req(input cbcv_pkg::in_t r, input bit typed,
                            input cbcv_pkg::out_t res);
        int gap;
        int n0;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge clk);
        end
        n0 = pending_results.size();
        predict_encryption(r);
        if (pending_results.size() != n0)
            req_total++;
        // A hand-written result replaces the predicted one for this row.
        if (typed)
        begin
            while (pending_results.size() > n0)
                void'(pending_results.pop_back());
            pending_results.push_back(res);
        end
        in_data <= r;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        cbcv_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("result %h with nothing expected", out_data));
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 16'(out_data.kind), 16'(want.kind));
                check_field("cipher_letter", 16'(out_data.cipher_letter),
                            16'(want.cipher_letter));
                check_field("is_pad", 16'(out_data.is_pad), 16'(want.is_pad));
                check_field("clean_count", out_data.clean_count, want.clean_count);
                check_field("pad_count", 16'(out_data.pad_count), 16'(want.pad_count));
                check_field("last_of_run", 16'(out_data.last_of_run),
                            16'(want.last_of_run));
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin : receiver
        int burst;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Main sequence: reset, directed table, random messages, closing stretch.
    initial
    begin : stimulus
        int  msg_len;
        int  wait_cnt;
        bit  first;

        cfg_blen = 4'd1;
        cfg_key = '0;
        cfg_iv = '0;
        reload_chain();
        pos_pred = 4'd0;
        count_pred = '0;

        // The first rows start from the reset state: zero key and IV, block of one.
        dir_tab = '{
            row_text_is(8'h61, 7'h61),
            row_text_is(8'h41, 7'h61),
            row_text(8'hFF),
            row_text(8'h40),
            row_text(8'h5B),
            row_text(8'h60),
            row_text(8'h7B),
            row_text_is(8'h5A, 7'h7A),
            row_text(8'h7A),
            row_end_is(8'hFF, 16'd4, 4'd0),
            row_end_is(8'h00, 16'd0, 4'd0),
            row_reg(cbcv_pkg::REG_BLOCK_LEN, 60'd0),
            row_reg(cbcv_pkg::REG_KEY, '1),
            row_reg(cbcv_pkg::REG_IV, '1),
            row_text(8'h6D),
            row_end(8'h00),
            row_reg(cbcv_pkg::REG_BLOCK_LEN, 60'd15),
            row_reg(cbcv_pkg::REG_KEY, 60'h0A3_19C8_52E7_4B61),
            row_reg(cbcv_pkg::REG_IV, 60'h5D2_8F03_6A1C_E947),
            row_text(8'h68),
            row_end(8'hFF),
            row_reg(cbcv_pkg::REG_BLOCK_LEN, 60'd5),
            row_text(8'h63),
            row_text(8'h42),
            row_text(8'h63),
            row_reg(cbcv_pkg::REG_BLOCK_LEN, 60'd2),
            row_end(8'h00),
            row_reg(cbcv_pkg::REG_BLOCK_LEN, 60'd4),
            row_text(8'h78),
            row_text(8'h59),
            row_reg(cbcv_pkg::REG_BLOCK_LEN, 60'd2),
            row_text(8'h6B),
            row_reg(cbcv_pkg::REG_IV, 60'd0),
            row_text(8'h51),
            row_reg(REG_NONE, '1),
            row_reg(cbcv_pkg::REG_BLOCK_LEN, 60'd12),
            row_text(8'h72),
            row_reg(cbcv_pkg::REG_KEY, 60'd0),
            row_end(8'hFF)
        };

        // Reset once.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        idle_on = 1'b1;
        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_tab[i].op == ROW_CFG)
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            else
                send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
        end

        // Random messages under random settings; some are cut short.
        req_total = 0;
        first = 1'b1;
        while (req_total < RAND_ITEMS)
        begin
            if ($urandom_range(0, 1) == 0)
                write_reg(cbcv_pkg::REG_BLOCK_LEN, 60'($urandom_range(0, 15)));
            if ($urandom_range(0, 2) == 0)
                write_reg(cbcv_pkg::REG_KEY, rand_letters());
            if ($urandom_range(0, 2) == 0)
                write_reg(cbcv_pkg::REG_IV, rand_letters());
            idle_on = ($urandom_range(0, 3) != 0);
            if (first)
            begin
                // Long receiver hold-off while a long message keeps coming.
                first = 1'b0;
                idle_on = 1'b1;
                long_hold = 1'b1;
                msg_len = 40;
            end
            else if ($urandom_range(0, 3) == 0)
                msg_len = $urandom_range(13, 40);
            else
                msg_len = $urandom_range(0, 12);
            for (int k = 0; k < msg_len; k++)
            begin
                // Occasionally change a register in the middle of a message.
                if (k == msg_len / 2 && $urandom_range(0, 4) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       write_reg(cbcv_pkg::REG_IV, rand_letters());
                        1:       write_reg(cbcv_pkg::REG_BLOCK_LEN,
                                           60'($urandom_range(0, 15)));
                        2:       write_reg(cbcv_pkg::REG_KEY, rand_letters());
                        default: write_reg(REG_NONE, rand_letters());
                    endcase
                end
                send_req(text_req(rand_text(1'b1)), 1'b0, '0);
            end
            if ($urandom_range(0, 7) != 0)
                send_req(end_req(8'($urandom_range(0, 255))), 1'b0, '0);
        end

        // Closing stretch without idling: back-to-back messages.
        idle_on = 1'b0;
        write_reg(cbcv_pkg::REG_BLOCK_LEN, 60'($urandom_range(1, 12)));
        for (int k = 0; k < TAIL_LETTERS; k++)
            send_req(text_req(rand_text(1'b0)), 1'b0, '0);
        send_req(end_req(8'($urandom_range(0, 255))), 1'b0, '0);
        for (int k = 0; k < 5; k++)
            send_req(text_req(rand_text(1'b1)), 1'b0, '0);
        send_req(end_req(8'($urandom_range(0, 255))), 1'b0, '0);

        // Drain and decide.
        in_valid <= 1'b0;
        for (wait_cnt = 0; wait_cnt < DRAIN_LIMIT && pending_results.size() != 0;
             wait_cnt++)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        if (fail_count == 0)
            $display("cbc_vigenere_encryptor_top verification clean");
        else
            $display("cbc_vigenere_encryptor_top verification failed");
        $finish;
    end

endmodule
